### hdl/ipacl_pkg.sv
package ipacl_pkg;

   localparam int PrefixEntriesDefault = 64;
   localparam int RuleEntriesDefault   = 32;
   localparam int NumSpacesDefault     = 64;
   localparam int NumKindsDefault      = 8;

   localparam logic [7:0] FullLen  = 8'd128;
   localparam logic [7:0] V4Limit  = 8'd32;
   localparam logic [7:0] V4Offset = 8'd96;
   localparam logic [7:0] HalfBits = 8'd64;

   typedef enum logic [2:0] {
      CMD_ADD_PREFIX = 3'd0,
      CMD_ADD_RULE   = 3'd1,
      CMD_CHECK      = 3'd2,
      CMD_REVERSE    = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REV_ALLOW = 2'd0,
      REV_NET64 = 2'd1,
      REV_EXACT = 2'd2,
      REV_NEVER = 2'd3
   } rev_mode_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_PREFIX = 2'd1,
      S_RULE   = 2'd2,
      S_DONE   = 2'd3
   } state_type;

   // Part of a len-bit prefix mask that falls in one 64-bit half; off is the half's start bit.
   function automatic logic [63:0] half_mask(input logic [7:0] len, input logic [7:0] off);
      logic [7:0] n;
      logic [63:0] m;
      begin
         if (len <= off) n = 8'd0;
         else if (len - off >= HalfBits) n = HalfBits;
         else n = len - off;
         if (n == 8'd0) m = '0;
         else m = ~64'd0 << (HalfBits - n);
         return m;
      end
   endfunction

endpackage

### hdl/ipacl_prefix_cell.sv
// One prefix entry. The probe address moves down the row one cell per cycle;
// each live cell that matches ORs its space bit into the bitmap it passes on.
module ipacl_prefix_cell
   import ipacl_pkg::*;
#(
   parameter int NumSpaces = NumSpacesDefault
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [63:0]          wr_hi,
   input  logic [63:0]          wr_lo,
   input  logic [7:0]           wr_len,
   input  logic [5:0]           wr_space,
   input  logic                 live,
   input  logic [63:0]          in_hi,
   input  logic [63:0]          in_lo,
   input  logic [NumSpaces-1:0] in_map,
   output logic [63:0]          out_hi,
   output logic [63:0]          out_lo,
   output logic [NumSpaces-1:0] out_map
);
   logic [63:0] hi_ff, lo_ff;
   logic [7:0] len_ff;
   logic [5:0] space_ff;
   logic [63:0] hi_out_ff, lo_out_ff;
   logic [NumSpaces-1:0] map_ff, map_in;
   logic hit;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hi_ff <= wr_hi;
         lo_ff <= wr_lo;
         len_ff <= wr_len;
         space_ff <= wr_space;
      end
   end

   // Match under the stored length.
   always_comb begin
      hit = (((in_hi ^ hi_ff) & half_mask(len_ff, 8'd0)) == '0) &&
            (((in_lo ^ lo_ff) & half_mask(len_ff, HalfBits)) == '0);
      map_in = in_map;
      if (live && hit && ({2'b00, space_ff} < 8'(NumSpaces)))
         map_in[space_ff[$clog2(NumSpaces)-1:0]] = 1'b1;
   end

   always_ff @(posedge clock) begin
      hi_out_ff <= in_hi;
      lo_out_ff <= in_lo;
      map_ff <= map_in;
   end

   assign out_hi = hi_out_ff;
   assign out_lo = lo_out_ff;
   assign out_map = map_ff;
endmodule

### hdl/ipacl_rule_cell.sv
// One rule entry. Kind and bitmap pass down the row; each live cell ORs in its hit.
module ipacl_rule_cell
   import ipacl_pkg::*;
#(
   parameter int NumSpaces = NumSpacesDefault
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [2:0]           wr_kind,
   input  logic [NumSpaces-1:0] wr_nets,
   input  logic                 live,
   input  logic [2:0]           in_kind,
   input  logic [NumSpaces-1:0] in_map,
   input  logic                 in_auth,
   output logic [2:0]           out_kind,
   output logic [NumSpaces-1:0] out_map,
   output logic                 out_auth
);
   logic [2:0] kind_ff, kind_out_ff;
   logic [NumSpaces-1:0] nets_ff, map_out_ff;
   logic auth_ff, auth_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         kind_ff <= wr_kind;
         nets_ff <= wr_nets;
      end
   end

   // A rule applies if its kind matches and it shares a space.
   assign auth_in = in_auth ||
                    (live && kind_ff == in_kind && (nets_ff & in_map) != '0);

   always_ff @(posedge clock) begin
      kind_out_ff <= in_kind;
      map_out_ff <= in_map;
      auth_ff <= auth_in;
   end

   assign out_kind = kind_out_ff;
   assign out_map = map_out_ff;
   assign out_auth = auth_ff;
endmodule

### hdl/ipv6_prefix_acl_checker_top.sv
// Add, rule, reverse, clear and unused commands answer through the S_DONE state.
// A check answers through S_PREFIX and then S_RULE, as the probe walks the
// prefix cell row and then the rule cell row.
// One item at a time; busy is high from acceptance until the result strobe.
// The receiver cannot stall; rsp_valid is high for exactly one cycle.
// Synchronous reset empties both tables, clears kind flags and reverse_mode.
module ipv6_prefix_acl_checker_top
   import ipacl_pkg::*;
#(
   parameter int PREFIX_ENTRIES = PrefixEntriesDefault,
   parameter int RULE_ENTRIES   = RuleEntriesDefault,
   parameter int NUM_SPACES     = NumSpacesDefault,
   parameter int NUM_KINDS      = NumKindsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [5:0]  req_net_index,
   input  logic [2:0]  req_rule_type,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [63:0] req_other_hi,
   input  logic [63:0] req_other_lo,
   input  logic [7:0]  req_prefix_len,
   input  logic [63:0] req_rule_nets,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_net_bitmap,
   output logic        rsp_authorized,
   output logic        rsp_type_active,
   output logic        rsp_reverse_ok,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int PW = $clog2(PREFIX_ENTRIES + 1);
   localparam int RW = $clog2(RULE_ENTRIES + 1);
   localparam int CW = $clog2(PREFIX_ENTRIES + RULE_ENTRIES + 2);

   state_type state_ff, state_in;
   logic [1:0] mode_ff;
   logic [PW-1:0] pcount_ff;
   logic [RW-1:0] rcount_ff;
   logic [7:0] seen_ff;
   logic [CW-1:0] cnt_ff;
   logic [2:0] kind_ff;
   logic kind_ok_ff;
   logic valid_ff;
   logic [1:0] status_ff;
   logic [63:0] map_out_ff;
   logic auth_ff, active_ff, rev_ff;
   logic [63:0] p_hi_ff, p_lo_ff;
   logic [7:0] len_adj;
   logic accept, cfg_wr;

   assign accept = start && !busy;
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr == 2'd0) ? {30'd0, mode_ff} : 32'd0;

   // V4-mapped lengths of at most 32 get 96 added.
   always_comb begin
      len_adj = req_prefix_len;
      if (req_addr_hi == '0 && req_addr_lo[63:32] == 32'h0000ffff &&
          req_prefix_len <= V4Limit)
         len_adj = req_prefix_len + V4Offset;
   end

   // Prefix cell row.
   logic [63:0] ph [PREFIX_ENTRIES+1];
   logic [63:0] pl [PREFIX_ENTRIES+1];
   logic [NUM_SPACES-1:0] pm [PREFIX_ENTRIES+1];
   logic p_wr;
   assign p_wr = accept && req_command == CMD_ADD_PREFIX && len_adj <= FullLen &&
                 pcount_ff < PW'(PREFIX_ENTRIES);
   assign ph[0] = p_hi_ff;
   assign pl[0] = p_lo_ff;
   assign pm[0] = '0;

   for (genvar i = 0; i < PREFIX_ENTRIES; i++) begin : g_pc
      ipacl_prefix_cell #(.NumSpaces(NUM_SPACES)) u_cell (
         .clock(clock),
         .wr_en(p_wr && pcount_ff == PW'(i)),
         .wr_hi(req_addr_hi), .wr_lo(req_addr_lo),
         .wr_len(len_adj), .wr_space(req_net_index),
         .live(pcount_ff > PW'(i)),
         .in_hi(ph[i]), .in_lo(pl[i]), .in_map(pm[i]),
         .out_hi(ph[i+1]), .out_lo(pl[i+1]), .out_map(pm[i+1])
      );
   end

   // Rule cell row, fed from the end of the prefix row.
   logic [2:0] rk [RULE_ENTRIES+1];
   logic [NUM_SPACES-1:0] rm [RULE_ENTRIES+1];
   logic ra [RULE_ENTRIES+1];
   logic r_wr;
   assign r_wr = accept && req_command == CMD_ADD_RULE &&
                 {2'b00, req_rule_type} < 5'(NUM_KINDS) &&
                 rcount_ff < RW'(RULE_ENTRIES);
   assign rk[0] = kind_ff;
   assign rm[0] = pm[PREFIX_ENTRIES];
   assign ra[0] = 1'b0;

   for (genvar j = 0; j < RULE_ENTRIES; j++) begin : g_rc
      ipacl_rule_cell #(.NumSpaces(NUM_SPACES)) u_cell (
         .clock(clock),
         .wr_en(r_wr && rcount_ff == RW'(j)),
         .wr_kind(req_rule_type), .wr_nets(req_rule_nets[NUM_SPACES-1:0]),
         .live(rcount_ff > RW'(j)),
         .in_kind(rk[j]), .in_map(rm[j]), .in_auth(ra[j]),
         .out_kind(rk[j+1]), .out_map(rm[j+1]), .out_auth(ra[j+1])
      );
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = (req_command == CMD_CHECK) ? S_PREFIX : S_DONE;
         S_PREFIX: if (cnt_ff == CW'(PREFIX_ENTRIES + RULE_ENTRIES - 1)) state_in = S_RULE;
         S_RULE: state_in = S_IDLE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

   // Counters, tables and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= REV_ALLOW;
         pcount_ff <= '0;
         rcount_ff <= '0;
         seen_ff <= '0;
         valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         valid_ff <= 1'b0;
         if (cfg_wr && paddr == 2'd0) mode_ff <= pwdata[1:0];
         if (state_ff == S_PREFIX) cnt_ff <= cnt_ff + 1'b1;
         if (state_ff == S_RULE || state_ff == S_DONE) valid_ff <= 1'b1;
         if (accept) begin
            cnt_ff <= '0;
            if (p_wr) pcount_ff <= pcount_ff + 1'b1;
            if (r_wr) begin
               rcount_ff <= rcount_ff + 1'b1;
               seen_ff[req_rule_type] <= 1'b1;
            end
            if (req_command == CMD_CLEAR) begin
               pcount_ff <= '0;
               rcount_ff <= '0;
               seen_ff <= '0;
               mode_ff <= REV_ALLOW;
            end
         end
      end
   end

   // Item payload and immediate results.
   always_ff @(posedge clock) begin
      if (accept) begin
         p_hi_ff <= req_addr_hi;
         p_lo_ff <= req_addr_lo;
         kind_ff <= req_rule_type;
         kind_ok_ff <= {2'b00, req_rule_type} < 5'(NUM_KINDS);
         status_ff <= ST_OK;
         map_out_ff <= '0;
         auth_ff <= 1'b0;
         active_ff <= 1'b0;
         rev_ff <= 1'b0;
         if (req_command == CMD_ADD_PREFIX) begin
            if (len_adj > FullLen) status_ff <= ST_INVALID;
            else if (!(pcount_ff < PW'(PREFIX_ENTRIES))) status_ff <= ST_FULL;
         end else if (req_command == CMD_ADD_RULE) begin
            if (!({2'b00, req_rule_type} < 5'(NUM_KINDS))) status_ff <= ST_INVALID;
            else if (!(rcount_ff < RW'(RULE_ENTRIES))) status_ff <= ST_FULL;
         end else if (req_command == CMD_REVERSE) begin
            unique case (rev_mode_type'(mode_ff))
               REV_NET64: rev_ff <= req_addr_hi == req_other_hi;
               REV_EXACT: rev_ff <= req_addr_hi == req_other_hi &&
                                    req_addr_lo == req_other_lo;
               REV_NEVER: rev_ff <= 1'b0;
               default:   rev_ff <= 1'b1;
            endcase
         end
      end else if (state_ff == S_RULE) begin
         map_out_ff <= 64'(rm[RULE_ENTRIES]);
         auth_ff <= kind_ok_ff && ra[RULE_ENTRIES];
         active_ff <= kind_ok_ff && seen_ff[kind_ff];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_net_bitmap = map_out_ff;
   assign rsp_authorized = auth_ff;
   assign rsp_type_active = active_ff;
   assign rsp_reverse_ok = rev_ff;
endmodule

### hdl/ipacl_checker.sv
// Port-level checks of the command handshake and result fields.
module ipacl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic        rsp_authorized,
   input logic        rsp_reverse_ok
);
   // An accepted item makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   // A result is a single-cycle strobe.
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   // The result ends the busy period.
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy during result");

   // Status never takes the unused code.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");

   // A check and a reverse check never answer together.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_authorized && rsp_reverse_ok)) else $error("mixed result");
endmodule

bind ipv6_prefix_acl_checker_top ipacl_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_authorized(rsp_authorized), .rsp_reverse_ok(rsp_reverse_ok)
);

### bench/tb_ipv6_prefix_acl_checker_top.sv
module tb_ipv6_prefix_acl_checker_top;
   import ipacl_pkg::*;

   localparam int PrefixCap = 64;
   localparam int RuleCap   = 32;
   localparam int KindCount = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [5:0]  req_net_index = '0;
   logic [2:0]  req_rule_type = '0;
   logic [63:0] req_addr_hi = '0;
   logic [63:0] req_addr_lo = '0;
   logic [63:0] req_other_hi = '0;
   logic [63:0] req_other_lo = '0;
   logic [7:0]  req_prefix_len = '0;
   logic [63:0] req_rule_nets = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_net_bitmap;
   logic        rsp_authorized;
   logic        rsp_type_active;
   logic        rsp_reverse_ok;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   ipv6_prefix_acl_checker_top uut (.*);

   always #5 clock = ~clock;

   // One expected verdict of the checker.
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] net_bitmap;
      logic        authorized;
      logic        type_active;
      logic        reverse_ok;
   } verdict_type;

   verdict_type pending_verdicts[$];
   int          mismatch_count = 0;
   int          sender_idle_pct = 0;

   // Shadow copy of the checker's tables and mode register.
   logic [1:0]  mode_shadow;
   int          prefix_fill;
   logic [63:0] pfx_hi[PrefixCap];
   logic [63:0] pfx_lo[PrefixCap];
   logic [7:0]  pfx_len[PrefixCap];
   logic [5:0]  pfx_space[PrefixCap];
   int          rule_fill;
   logic [2:0]  rule_kind[RuleCap];
   logic [63:0] rule_space[RuleCap];
   logic [KindCount-1:0] kind_flags;

   function automatic logic [63:0] lead_ones(input int n);
      if (n <= 0) return '0;
      if (n >= 64) return '1;
      return ~64'd0 << (64 - n);
   endfunction

   // Works out the verdict of one command and updates the shadow tables.
   function automatic verdict_type acl_apply(input logic [2:0] cmd, input logic [5:0] space,
         input logic [2:0] kind, input logic [63:0] ahi, input logic [63:0] alo,
         input logic [63:0] ohi, input logic [63:0] olo, input logic [7:0] plen,
         input logic [63:0] nets);
      verdict_type v;
      int len;
      v = '0;
      len = plen;
      case (cmd)
         CMD_ADD_PREFIX: begin
            if (ahi == 0 && alo[63:32] == 32'h0000ffff && len <= 32) len += 96;
            if (len > 128) v.status = ST_INVALID;
            else if (prefix_fill >= PrefixCap) v.status = ST_FULL;
            else begin
               pfx_hi[prefix_fill] = ahi;
               pfx_lo[prefix_fill] = alo;
               pfx_len[prefix_fill] = 8'(len);
               pfx_space[prefix_fill] = space;
               prefix_fill++;
            end
         end
         CMD_ADD_RULE: begin
            if (rule_fill >= RuleCap) v.status = ST_FULL;
            else begin
               rule_kind[rule_fill] = kind;
               rule_space[rule_fill] = nets;
               rule_fill++;
               kind_flags[kind] = 1'b1;
            end
         end
         CMD_CHECK: begin
            for (int i = 0; i < prefix_fill; i++)
               if (((ahi ^ pfx_hi[i]) & lead_ones(pfx_len[i])) == 0 &&
                   ((alo ^ pfx_lo[i]) & lead_ones(int'(pfx_len[i]) - 64)) == 0)
                  v.net_bitmap[pfx_space[i]] = 1'b1;
            for (int i = 0; i < rule_fill; i++)
               if (rule_kind[i] == kind && (rule_space[i] & v.net_bitmap) != 0)
                  v.authorized = 1'b1;
            v.type_active = kind_flags[kind];
         end
         CMD_REVERSE: begin
            case (mode_shadow)
               REV_NET64: v.reverse_ok = (ahi == ohi);
               REV_EXACT: v.reverse_ok = (ahi == ohi && alo == olo);
               REV_NEVER: v.reverse_ok = 1'b0;
               default:   v.reverse_ok = 1'b1;
            endcase
         end
         CMD_CLEAR: begin
            prefix_fill = 0;
            rule_fill = 0;
            kind_flags = '0;
            mode_shadow = REV_ALLOW;
         end
         default: ;
      endcase
      return v;
   endfunction

   // Sends one item and predicts its verdict once the checker is no longer busy.
   task automatic send_item(input logic [2:0] cmd, input logic [5:0] space,
         input logic [2:0] kind, input logic [63:0] ahi, input logic [63:0] alo,
         input logic [63:0] ohi, input logic [63:0] olo, input logic [7:0] plen,
         input logic [63:0] nets);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      start <= 1'b1;
      req_command <= cmd;
      req_net_index <= space;
      req_rule_type <= kind;
      req_addr_hi <= ahi;
      req_addr_lo <= alo;
      req_other_hi <= ohi;
      req_other_lo <= olo;
      req_prefix_len <= plen;
      req_rule_nets <= nets;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_verdicts.push_back(acl_apply(cmd, space, kind, ahi, alo, ohi, olo, plen, nets));
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the mode register over the bus while the checker is idle.
   task automatic write_mode(input logic [1:0] mode);
      wait_drained();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 2'd0;
      pwdata <= {30'd0, mode};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      mode_shadow = mode;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_clear();
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
   endtask

   // Checks each verdict against the oldest prediction.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("verdict with none expected");
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_net_bitmap !== want.net_bitmap) begin
               $error("net_bitmap: expected %h, got %h", want.net_bitmap, rsp_net_bitmap);
               mismatch_count++;
            end
            if (rsp_authorized !== want.authorized) begin
               $error("authorized: expected %0b, got %0b", want.authorized, rsp_authorized);
               mismatch_count++;
            end
            if (rsp_type_active !== want.type_active) begin
               $error("type_active: expected %0b, got %0b", want.type_active,
                      rsp_type_active);
               mismatch_count++;
            end
            if (rsp_reverse_ok !== want.reverse_ok) begin
               $error("reverse_ok: expected %0b, got %0b", want.reverse_ok, rsp_reverse_ok);
               mismatch_count++;
            end
         end
      end
   end

   // Directed: length extremes, the v4-mapped case, full tables and unused commands.
   task automatic test_directed();
      send_item(CMD_ADD_PREFIX, 6'd63, 0, '1, '1, 0, 0, 8'd128, 0);
      send_item(CMD_ADD_PREFIX, 6'd0, 0, 0, 0, 0, 0, 8'd0, 0);
      send_item(CMD_ADD_PREFIX, 6'd1, 0, 0, 64'h0000ffff_c0a80100, 0, 0, 8'd24, 0);
      send_item(CMD_ADD_PREFIX, 6'd2, 0, 0, 64'h0000ffff_0a000000, 0, 0, 8'd33, 0);
      send_item(CMD_ADD_PREFIX, 6'd3, 0, 0, 0, 0, 0, 8'd129, 0);
      send_item(CMD_ADD_PREFIX, 6'd3, 0, 0, 0, 0, 0, 8'd255, 0);
      send_item(CMD_ADD_RULE, 0, 3'd7, 0, 0, 0, 0, 0, '1);
      send_item(CMD_ADD_RULE, 0, 3'd0, 0, 0, 0, 0, 0, 64'h2);
      send_item(CMD_CHECK, 0, 3'd0, 0, 64'h0000ffff_c0a801fe, 0, 0, 0, 0);
      send_item(CMD_CHECK, 0, 3'd7, '1, '1, 0, 0, 0, 0);
      send_item(CMD_CHECK, 0, 3'd5, '1, '1, 0, 0, 0, 0);
      send_item(3'd5, '1, '1, '1, '1, '1, '1, '1, '1);
      send_item(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 66; i++)
         send_item(CMD_ADD_PREFIX, 6'(i), 0, rand64(), rand64(), 0, 0,
                   8'($urandom_range(128)), 0);
      for (int i = 0; i < 34; i++)
         send_item(CMD_ADD_RULE, 0, 3'(i), 0, 0, 0, 0, 0, rand64());
      send_item(CMD_CHECK, 0, 3'd2, rand64(), rand64(), 0, 0, 0, 0);
      send_clear();
   endtask

   // Reverse check under every mode, extremes included.
   task automatic test_reverse_modes();
      logic [63:0] a, b;
      for (int m = 3; m >= 0; m--) begin
         write_mode(2'(m));
         for (int i = 0; i < 12; i++) begin
            a = rand64();
            b = rand64();
            send_item(CMD_REVERSE, 0, 0, a, b, (i % 3 == 0) ? a : rand64(),
                      (i % 2 == 0) ? b : rand64(), 0, 0);
         end
      end
      write_mode(REV_EXACT);
      send_clear();
      send_item(CMD_REVERSE, 0, 0, 1, 2, 3, 4, 0, 0);
   endtask

   // Random sessions: a few prefixes and rules, then checks on their addresses, some altered.
   task automatic test_random_sessions(input int items);
      logic [63:0] hi_pool[8], lo_pool[8];
      int n, k;
      n = 0;
      while (n < items) begin
         for (int i = 0; i < 8; i++) begin
            hi_pool[i] = rand64();
            lo_pool[i] = rand64();
         end
         for (int i = 0; i < $urandom_range(10, 2); i++) begin
            k = $urandom_range(7);
            send_item(CMD_ADD_PREFIX, 6'($urandom), 0, hi_pool[k], lo_pool[k], 0, 0,
                      8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(128)), 0);
            n++;
         end
         for (int i = 0; i < $urandom_range(6, 1); i++) begin
            send_item(CMD_ADD_RULE, 0, 3'($urandom), 0, 0, 0, 0, 0, rand64());
            n++;
         end
         for (int i = 0; i < $urandom_range(14, 4); i++) begin
            k = $urandom_range(7);
            send_item(($urandom_range(5) == 0) ? 3'($urandom) : CMD_CHECK, 6'($urandom),
                      3'($urandom), hi_pool[k] ^ ($urandom_range(1) ? 0 : rand64()),
                      lo_pool[k] ^ ($urandom_range(1) ? 0 : rand64()),
                      rand64(), rand64(), 8'($urandom), rand64());
            n++;
         end
         if ($urandom_range(3) == 0) begin
            send_clear();
            n++;
         end
      end
   endtask

   initial begin
      mode_shadow = REV_ALLOW;
      prefix_fill = 0;
      rule_fill = 0;
      kind_flags = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_reverse_modes();
      sender_idle_pct = 35;
      test_random_sessions(370);
      wait_drained();
      write_mode(REV_NET64);
      sender_idle_pct = 63;
      test_random_sessions(370);
      wait_drained();
      sender_idle_pct = 0;
      test_random_sessions(370);
      wait_drained();
      repeat (110) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #20000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
hdl/ipacl_pkg.sv
hdl/ipacl_prefix_cell.sv
hdl/ipacl_rule_cell.sv
hdl/ipv6_prefix_acl_checker_top.sv
hdl/ipacl_checker.sv
bench/tb_ipv6_prefix_acl_checker_top.sv
